>>> sv/assert_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is active.
`define RWAT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset.
`define RWAT_ASSERT_ANY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rwat_pkg.sv
`timescale 1ns / 1ps

package rwat_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int OBJ_W   = 8;
   localparam int KIND_W  = 2;
   localparam int OWNER_W = 8;
   localparam int LIMIT_W = 5;
   localparam int COUNT_W = 5;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIMIT_W-1:0] MAX_ACTIVE_RESET = LIMIT_W'(16);

   // Word index of the limit register in the register map.
   localparam logic REG_MAX_ACTIVE = 1'b0;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_READ = '0;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_CONFLICT  = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [OBJ_W-1:0]   object;
      logic [KIND_W-1:0]  kind;
      logic [OWNER_W-1:0] owner;
   } slot_entry_type;

   typedef struct packed {
      logic               set;
      logic               clear;
      logic [IDX_W-1:0]   index;
      logic [OBJ_W-1:0]   object;
      logic [KIND_W-1:0]  kind;
      logic [OWNER_W-1:0] owner;
   } slot_write_type;

   typedef struct packed {
      logic free;
      logic exact;
      logic conflict;
      logic identical;
   } match_type;

endpackage

>>> sv/rwat_channels.sv
`timescale 1ns / 1ps

interface rwat_req_if;
   import rwat_pkg::*;

   logic               valid;
   logic               ready;
   logic               operation;
   logic [OBJ_W-1:0]   object_id;
   logic [KIND_W-1:0]  access_kind;
   logic [OWNER_W-1:0] requester;

   modport source (output valid, output operation, output object_id,
                   output access_kind, output requester, input ready);
   modport sink   (input valid, input operation, input object_id,
                   input access_kind, input requester, output ready);
endinterface

interface rwat_rsp_if;
   import rwat_pkg::*;

   logic               valid;
   logic               ready;
   logic               granted;
   logic [1:0]         status;
   logic [COUNT_W-1:0] active_count;

   modport source (output valid, output granted, output status,
                   output active_count, input ready);
   modport sink   (input valid, input granted, input status,
                   input active_count, output ready);
endinterface

>>> sv/rwat_slots.sv
`timescale 1ns / 1ps

module rwat_slots (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [rwat_pkg::IDX_W-1:0] rd_addr,
   output rwat_pkg::slot_entry_type rd_entry,
   input  rwat_pkg::slot_write_type wr
);
   import rwat_pkg::*;

   logic [OBJ_W-1:0]   obj_mem   [TABLE_DEPTH];
   logic [KIND_W-1:0]  kind_mem  [TABLE_DEPTH];
   logic [OWNER_W-1:0] owner_mem [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] valid_ff;
   slot_entry_type         rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.set) begin
         obj_mem[wr.index]   <= wr.object;
         kind_mem[wr.index]  <= wr.kind;
         owner_mem[wr.index] <= wr.owner;
      end
      if (rd_en) begin
         rd_entry_ff.valid  <= valid_ff[rd_addr];
         rd_entry_ff.object <= obj_mem[rd_addr];
         rd_entry_ff.kind   <= kind_mem[rd_addr];
         rd_entry_ff.owner  <= owner_mem[rd_addr];
      end
   end

   // Occupancy flags live in flops so that reset empties the table at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.set) begin
         valid_ff[wr.index] <= 1'b1;
      end else if (wr.clear) begin
         valid_ff[wr.index] <= 1'b0;
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> sv/rwat_match.sv
`timescale 1ns / 1ps

module rwat_match (
   input  rwat_pkg::slot_entry_type   entry,
   input  logic [rwat_pkg::OBJ_W-1:0]   object_id,
   input  logic [rwat_pkg::KIND_W-1:0]  access_kind,
   input  logic [rwat_pkg::OWNER_W-1:0] requester,
   output rwat_pkg::match_type        result
);
   import rwat_pkg::*;

   logic same_obj;
   logic both_read;

   assign same_obj  = entry.valid && (entry.object == object_id);
   assign both_read = (access_kind == KIND_READ) && (entry.kind == KIND_READ);

   always_comb begin
      result.free      = !entry.valid;
      result.exact     = same_obj && (entry.kind == access_kind) &&
                         (entry.owner == requester);
      // Two reads of one object share it; any write on it excludes the rest.
      result.conflict  = same_obj && !both_read;
      result.identical = same_obj && both_read && (entry.owner == requester);
   end

endmodule

>>> sv/reader_writer_admission_table.sv
`timescale 1ns / 1ps
// Reader/writer admission table.
// Requests arrive as beats on req_bus (acquire or release of an object by a
// requester); each request yields exactly one response beat on rsp_bus with
// granted, status and the number of active entries afterwards.
// The limit on active entries is the max_active register at byte address 0
// of the csr_ port; writes to it take effect for the next request.
// An acquire that finds the limit or the table full skips the scan and goes
// straight to the final step. Every other request scans all table slots
// through one compare unit, one slot per cycle, behind the registered read
// of the slot memory. req_bus.ready is high only while no request is in work,
// so a new request is taken only once the last one has left the final step.
// The response sits in an output register; a new request is taken while it
// waits, and the next response waits in the final step until rsp_bus.ready
// frees that register.
// Reset empties the table, sets the count to zero, restores the limit to 16
// and drops any pending response.
module reader_writer_admission_table (
   input  logic                          clock,
   input  logic                          reset,
   rwat_req_if.sink                      req_bus,
   rwat_rsp_if.source                    rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rwat_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rwat_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rwat_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import rwat_pkg::*;

   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic               op_ff, op_in;
   logic [OBJ_W-1:0]   obj_ff, obj_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [OWNER_W-1:0] who_ff, who_in;
   logic               full_ff, full_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               issue_done_ff, issue_done_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               cmp_last_ff, cmp_last_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               conflict_ff, conflict_in;
   logic               identical_ff, identical_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [LIMIT_W-1:0] max_active_ff, max_active_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               granted_ff, granted_in;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] active_ff, active_in;

   logic           accept;
   logic           table_full;
   logic           rd_en;
   slot_entry_type rd_entry;
   slot_write_type wr;
   match_type      match;
   logic           csr_write;

   rwat_slots u_slots (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (scan_idx_ff),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   rwat_match u_match (
      .entry       (rd_entry),
      .object_id   (obj_ff),
      .access_kind (kind_ff),
      .requester   (who_ff),
      .result      (match)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign table_full = (CMP_W'(used_ff) >= CMP_W'(max_active_ff)) ||
                       (used_ff >= CNT_W'(TABLE_DEPTH));

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_MAX_ACTIVE);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_MAX_ACTIVE) ?
                       CSR_DATA_W'(max_active_ff) : '0;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      obj_in        = obj_ff;
      kind_in       = kind_ff;
      who_in        = who_ff;
      full_in       = full_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_idx_in    = scan_idx_ff;
      conflict_in   = conflict_ff;
      identical_in  = identical_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      used_in       = used_ff;
      max_active_in = max_active_ff;
      rsp_valid_in  = rsp_valid_ff;
      granted_in    = granted_ff;
      status_in     = status_ff;
      active_in     = active_ff;
      rd_en         = 1'b0;
      wr            = '0;

      if (csr_write) begin
         max_active_in = csr_pwdata[LIMIT_W-1:0];
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_bus.operation;
               obj_in        = req_bus.object_id;
               kind_in       = req_bus.access_kind;
               who_in        = req_bus.requester;
               full_in       = (req_bus.operation == OP_ACQUIRE) && table_full;
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               conflict_in   = 1'b0;
               identical_in  = 1'b0;
               free_found_in = 1'b0;
               hit_found_in  = 1'b0;
               state_in      = full_in ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               rd_en       = 1'b1;
               scan_idx_in = scan_idx_ff + 1'b1;
               if (scan_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            // Slot data returns in the cycle after its read was issued.
            if (cmp_vld_ff) begin
               if (match.exact && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = cmp_idx_ff;
               end
               if (match.conflict) begin
                  conflict_in = 1'b1;
               end
               if (match.identical) begin
                  identical_in = 1'b1;
               end
               if (match.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (cmp_last_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == OP_RELEASE) begin
                  if (hit_found_ff) begin
                     granted_in = 1'b1;
                     status_in  = STATUS_OK;
                     wr.clear   = 1'b1;
                     wr.index   = hit_idx_ff;
                     used_in    = used_ff - 1'b1;
                  end else begin
                     granted_in = 1'b0;
                     status_in  = STATUS_NOT_FOUND;
                  end
               end else if (full_ff) begin
                  granted_in = 1'b0;
                  status_in  = STATUS_FULL;
               end else if (conflict_ff) begin
                  granted_in = 1'b0;
                  status_in  = STATUS_CONFLICT;
               end else begin
                  granted_in = 1'b1;
                  status_in  = STATUS_OK;
                  // A read already held by the same requester is not stored twice.
                  if (!identical_ff && free_found_ff) begin
                     wr.set    = 1'b1;
                     wr.index  = free_idx_ff;
                     wr.object = obj_ff;
                     wr.kind   = kind_ff;
                     wr.owner  = who_ff;
                     used_in   = used_ff + 1'b1;
                  end
               end
               active_in = COUNT_W'(used_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      cmp_vld_in  = rd_en;
      cmp_last_in = rd_en && (scan_idx_ff == LAST_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         cmp_last_ff   <= 1'b0;
         used_ff       <= '0;
         max_active_ff <= MAX_ACTIVE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         cmp_last_ff   <= cmp_last_in;
         used_ff       <= used_in;
         max_active_ff <= max_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      obj_ff        <= obj_in;
      kind_ff       <= kind_in;
      who_ff        <= who_in;
      full_ff       <= full_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      conflict_ff   <= conflict_in;
      identical_ff  <= identical_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      granted_ff    <= granted_in;
      status_ff     <= status_in;
      active_ff     <= active_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.granted      = granted_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.active_count = active_ff;

endmodule

>>> sv/rwat_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rwat_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_granted,
   input logic [1:0]                    rsp_status,
   input logic [rwat_pkg::COUNT_W-1:0]  rsp_active_count
);
   import rwat_pkg::*;

   // A response beat that is not taken stays put.
   `RWAT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_granted) && $stable(rsp_active_count), "stalled response beat changed")

   // Granted is reported exactly when the status is ok.
   `RWAT_ASSERT(a_grant_status, clock, reset, rsp_valid |-> (rsp_granted == (rsp_status == STATUS_OK)), "granted and status disagree")

   // Only one request is in work at a time.
   `RWAT_ASSERT(a_one_in_work, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while another is in work")

   // Reset drops any pending response.
   `RWAT_ASSERT_ANY(a_reset_clears, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind reader_writer_admission_table rwat_checker u_rwat_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_granted      (rsp_bus.granted),
   .rsp_status       (rsp_bus.status),
   .rsp_active_count (rsp_bus.active_count)
);

>>> sim/rwat_admission_checker.sv
`timescale 1ns / 1ps

module rwat_admission_checker
   import rwat_pkg::*;
#(
   parameter logic [CSR_ADDR_W-1:0] LIMIT_ADDR = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   rwat_req_if                   req_tap,
   rwat_rsp_if                   rsp_tap,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic               granted;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } admission_type;

   slot_entry_type     entry_mem [TABLE_DEPTH];
   int                 active_entries;
   logic [LIMIT_W-1:0] entry_limit;
   admission_type      pending_answers [$];
   int                 failures = 0;

   // Admission decision for one request beat; updates the shadow table.
   function automatic admission_type admit(input logic op, input logic [OBJ_W-1:0] obj,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [OWNER_W-1:0] who);
      admission_type res;
      int            free_idx;
      bit            same_read;
      bit            blocked;
      res.granted = 1'b0;
      res.status  = STATUS_OK;
      free_idx    = -1;
      same_read   = 1'b0;
      blocked     = 1'b0;
      if (op == OP_RELEASE) begin
         res.status = STATUS_NOT_FOUND;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!res.granted && entry_mem[i].valid && entry_mem[i].object == obj &&
                entry_mem[i].kind == kind && entry_mem[i].owner == who) begin
               entry_mem[i].valid = 1'b0;
               active_entries--;
               res.granted = 1'b1;
               res.status  = STATUS_OK;
            end
         end
      end else if (active_entries >= int'(entry_limit) || active_entries >= TABLE_DEPTH) begin
         // The limit wins over every other test, even for an identical read.
         res.status = STATUS_FULL;
      end else begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!entry_mem[i].valid) begin
               if (free_idx < 0) free_idx = i;
            end else if (entry_mem[i].object == obj) begin
               if (kind != KIND_READ || entry_mem[i].kind != KIND_READ) blocked = 1'b1;
               else if (entry_mem[i].owner == who) same_read = 1'b1;
            end
         end
         if (blocked) begin
            res.status = STATUS_CONFLICT;
         end else begin
            res.granted = 1'b1;
            if (!same_read && free_idx >= 0) begin
               entry_mem[free_idx] = '{valid: 1'b1, object: obj, kind: kind, owner: who};
               active_entries++;
            end
         end
      end
      res.count = COUNT_W'(active_entries);
      return res;
   endfunction

   function automatic void flag_field(input string field, input int want, input int got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      failures++;
   endfunction

   always @(posedge clock) begin
      admission_type want;
      if (reset) begin
         foreach (entry_mem[i]) entry_mem[i].valid = 1'b0;
         active_entries = 0;
         entry_limit    = MAX_ACTIVE_RESET;
         pending_answers.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LIMIT_ADDR)
            entry_limit = csr_pwdata[LIMIT_W-1:0];
         if (rsp_tap.valid && rsp_tap.ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response beat, expected none actual %0d/%0d/%0d",
                        $time, rsp_tap.granted, rsp_tap.status, rsp_tap.active_count);
               failures++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tap.granted !== want.granted)
                  flag_field("granted", want.granted, rsp_tap.granted);
               if (rsp_tap.status !== want.status)
                  flag_field("status", want.status, rsp_tap.status);
               if (rsp_tap.active_count !== want.count)
                  flag_field("active_count", want.count, rsp_tap.active_count);
            end
         end
         if (req_tap.valid && req_tap.ready)
            pending_answers = {pending_answers,
                               admit(req_tap.operation, req_tap.object_id,
                                     req_tap.access_kind, req_tap.requester)};
      end
      outstanding <= pending_answers.size();
      fail_count  <= failures;
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rwat_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MAX_ACTIVE_ADDR = CSR_ADDR_W'({REG_MAX_ACTIVE, 2'b00});
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_AFTER    = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_FROM    = 1000;
   localparam int QUIET_TO      = 1250;
   localparam int IDLE_PCT      = 37;

   typedef struct packed {
      logic               op;
      logic [OBJ_W-1:0]   object;
      logic [KIND_W-1:0]  kind;
      logic [OWNER_W-1:0] owner;
   } access_request_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    outstanding;
   int                    accepted_reqs = 0;
   int                    cycle_count = 0;
   access_request_type    acquired_recently [$];

   rwat_req_if req_bus ();
   rwat_rsp_if rsp_bus ();

   reader_writer_admission_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rwat_admission_checker #(.LIMIT_ADDR(MAX_ACTIVE_ADDR)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tap     (req_bus),
      .rsp_tap     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("reader_writer_admission_table: mismatch");
         $finish;
      end
   end

   function automatic bit quiet_window();
      return accepted_reqs >= QUIET_FROM && accepted_reqs < QUIET_TO;
   endfunction

   // Response side: random stalls, one long hold-off so the block backs up
   // into its input, and a stretch with ready held high.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (quiet_window() || reset) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic access_request_type make_req(input logic op, input int obj,
                                                   input int kind, input int who);
      return '{op: op, object: OBJ_W'(obj), kind: KIND_W'(kind), owner: OWNER_W'(who)};
   endfunction

   task automatic send_request(input access_request_type r);
      if (!quiet_window()) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= r.op;
      req_bus.object_id   <= r.object;
      req_bus.access_kind <= r.kind;
      req_bus.requester   <= r.owner;
      do @(posedge clock); while (!req_bus.ready);
      accepted_reqs++;
   endtask

   task automatic set_max_active(input int value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_ACTIVE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly acquire/release pairs on a small pool of objects and owners, so
   // that sharing, conflicts and exact matches come up often.
   function automatic access_request_type next_request(input int release_pct, input bit spread);
      access_request_type r;
      int                 idx;
      if ($urandom_range(0, 99) < release_pct && acquired_recently.size() > 0 &&
          $urandom_range(0, 9) != 0) begin
         idx = $urandom_range(0, acquired_recently.size() - 1);
         r = acquired_recently[idx];
         acquired_recently.delete(idx);
         r.op = OP_RELEASE;
         return r;
      end
      r.op = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_ACQUIRE;
      if (spread || $urandom_range(0, 3) == 0) r.object = OBJ_W'($urandom_range(0, 255));
      else r.object = OBJ_W'($urandom_range(0, 7));
      r.kind  = $urandom_range(0, 1) ? KIND_READ : KIND_W'($urandom_range(1, 3));
      r.owner = ($urandom_range(0, 3) == 0) ? OWNER_W'($urandom_range(0, 255))
                                            : OWNER_W'($urandom_range(0, 3));
      if (r.op == OP_ACQUIRE) begin
         acquired_recently = {acquired_recently, r};
         if (acquired_recently.size() > 32) void'(acquired_recently.pop_front());
      end
      return r;
   endfunction

   task automatic run_phase(input int limit, input int count, input int release_pct,
                            input bit spread);
      set_max_active(limit);
      repeat (count) send_request(next_request(release_pct, spread));
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.operation   <= OP_ACQUIRE;
      req_bus.object_id   <= '0;
      req_bus.access_kind <= KIND_READ;
      req_bus.requester   <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Shared reads, identical read, writes against reads and against writes.
      send_request(make_req(OP_ACQUIRE, 0, 0, 0));
      send_request(make_req(OP_ACQUIRE, 0, 0, 0));
      send_request(make_req(OP_ACQUIRE, 0, 0, 255));
      send_request(make_req(OP_ACQUIRE, 0, 1, 7));
      send_request(make_req(OP_ACQUIRE, 255, 3, 255));
      send_request(make_req(OP_ACQUIRE, 255, 0, 1));
      send_request(make_req(OP_ACQUIRE, 255, 3, 255));
      send_request(make_req(OP_ACQUIRE, 128, 2, 128));
      send_request(make_req(OP_RELEASE, 255, 3, 255));
      send_request(make_req(OP_RELEASE, 255, 3, 255));
      send_request(make_req(OP_RELEASE, 0, 0, 0));
      send_request(make_req(OP_RELEASE, 128, 1, 128));
      // Limit below the count: even an identical read is refused as full.
      set_max_active(1);
      send_request(make_req(OP_ACQUIRE, 0, 0, 255));
      send_request(make_req(OP_ACQUIRE, 77, 2, 3));
      set_max_active(0);
      send_request(make_req(OP_ACQUIRE, 200, 0, 9));
      send_request(make_req(OP_RELEASE, 128, 2, 128));
      send_request(make_req(OP_RELEASE, 0, 0, 255));
      send_request(make_req(OP_ACQUIRE, 0, 0, 255));

      run_phase(16, 250, 45, 1'b0);
      run_phase(31, 200, 15, 1'b1);
      run_phase(1, 100, 40, 1'b0);
      run_phase(0, 60, 50, 1'b0);
      run_phase(16, 250, 20, 1'b1);
      run_phase(5, 200, 45, 1'b0);
      run_phase(17, 300, 30, 1'b1);
      run_phase(16, 300, 45, 1'b0);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("reader_writer_admission_table: match");
      end else begin
         $display("reader_writer_admission_table: mismatch");
      end
      $finish;
   end

endmodule
